FILE: hw/rtl/lrud_pkg.sv
// ----------------------------------------------------------------------------
// lrud_pkg
// Shared types and command codes for the LRU tile cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package lrud_pkg;

  localparam int CmdW   = 3;
  localparam int ZoomW  = 5;
  localparam int CoordW = 24;
  localparam int SlotW  = 6;
  localparam int LimW   = 7;

  localparam logic [CmdW-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 3'd1;
  localparam logic [CmdW-1:0] CMD_PROBE  = 3'd2;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [LimW-1:0] LIMIT_RESET = 7'd64;

  // broadcast age update control, same for every entry
  typedef struct packed {
    logic clear;
    logic inc_below;
    logic inc_all;
    logic dec_above;
  } lrud_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrud_entry.sv
// ----------------------------------------------------------------------------
// lrud_entry
// One directory entry: valid bit, tile key, recency age and key match.
// ----------------------------------------------------------------------------
`default_nettype none

module lrud_entry import lrud_pkg::*; #(
  parameter int KeyBits = 24,
  parameter int AgeBits = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrud_ctl_t          ctl,
  input  wire logic [AgeBits-1:0] ref_age,
  input  wire logic               wr,
  input  wire logic               kill,
  input  wire logic               touched,
  input  wire logic [ZoomW-1:0]   in_z,
  input  wire logic [KeyBits-1:0] in_x,
  input  wire logic [KeyBits-1:0] in_y,
  output logic                    valid,
  output logic                    match,
  output logic [AgeBits-1:0]      age,
  output logic [ZoomW-1:0]        key_z,
  output logic [KeyBits-1:0]      key_x,
  output logic [KeyBits-1:0]      key_y
);

  assign match = valid && (key_z == in_z) && (key_x == in_x) && (key_y == in_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (kill) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_z <= in_z;
      key_x <= in_x;
      key_y <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (wr || touched) begin
      age <= '0;
    end else if (valid) begin
      if (ctl.inc_all || (ctl.inc_below && (age < ref_age))) begin
        age <= age + 1'b1;
      end else if (ctl.dec_above && (age > ref_age)) begin
        age <= age - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_tile_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_tile_cache_directory
// Fully associative tile key directory with least recently used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A command (lookup, insert, probe, remove, clear) and a tile key are
//   transferred at a rising edge with start high and busy low. busy stays
//   low, so a command can be issued in every cycle.
//   Each command gives exactly one result, shown for one cycle with done
//   high: hit, slot and, for an insert that displaced the least recent entry,
//   evicted and the displaced key. The receiver cannot stall the results.
//   Throughput is one command per cycle. The command is registered, then
//   the full key compare, age update and slot choice over all ENTRIES
//   entries run in the next cycle and write the result register.
//   max_entries is written with max_entries_we while no command is in
//   flight; 0 acts as 1 and values above ENTRIES act as ENTRIES.
//   Synchronous reset empties the directory and sets the limit to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_tile_cache_directory import lrud_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int COORD_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              max_entries_we,
  input  wire logic [LimW-1:0]   max_entries,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CmdW-1:0]   command,
  input  wire logic [ZoomW-1:0]  tile_z,
  input  wire logic [CoordW-1:0] tile_x,
  input  wire logic [CoordW-1:0] tile_y,
  output logic                   done,
  output logic                   hit,
  output logic [SlotW-1:0]       slot,
  output logic                   evicted,
  output logic [ZoomW-1:0]       evicted_z,
  output logic [CoordW-1:0]      evicted_x,
  output logic [CoordW-1:0]      evicted_y
);

  localparam int KB = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int AW = $clog2(ENTRIES);
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int LW = (OW > LimW) ? OW : LimW;

  logic [LimW-1:0]  limit;
  logic             req_v;
  logic [CmdW-1:0]  req_cmd;
  logic [ZoomW-1:0] req_z;
  logic [KB-1:0]    req_x;
  logic [KB-1:0]    req_y;
  logic [OW-1:0]    occ;
  logic [OW-1:0]    occ_next;

  logic [ENTRIES-1:0] ent_valid;
  logic [ENTRIES-1:0] ent_match;
  logic [ENTRIES-1:0] ent_wr;
  logic [ENTRIES-1:0] ent_kill;
  logic [ENTRIES-1:0] ent_touch;
  logic [AW-1:0]      ent_age [ENTRIES];
  logic [ZoomW-1:0]   ent_z   [ENTRIES];
  logic [KB-1:0]      ent_x   [ENTRIES];
  logic [KB-1:0]      ent_y   [ENTRIES];

  lrud_ctl_t          ctl;
  logic [AW-1:0]      ref_age;
  logic               is_lookup, is_insert, is_probe, is_remove, is_clear;
  logic               any_hit, full, evict, ins_miss;
  logic [AW-1:0]      hit_idx, free_idx, hit_age, oldest_age;
  logic [LW-1:0]      lim_ext, lim_eff;
  logic [ENTRIES-1:0] victim_oh, free_vec, free_oh;
  logic [ZoomW-1:0]   vic_z;
  logic [KB-1:0]      vic_x, vic_y;
  logic [AW-1:0]      slot_idx;
  logic [AW+SlotW-1:0] slot_wide;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (max_entries_we) begin
      limit <= max_entries;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else begin
      req_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_cmd <= command;
      req_z   <= tile_z;
      req_x   <= tile_x[KB-1:0];
      req_y   <= tile_y[KB-1:0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_ent
      lrud_entry #(
        .KeyBits(KB),
        .AgeBits(AW)
      ) u_entry (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .ref_age (ref_age),
        .wr      (ent_wr[g]),
        .kill    (ent_kill[g]),
        .touched (ent_touch[g]),
        .in_z    (req_z),
        .in_x    (req_x),
        .in_y    (req_y),
        .valid   (ent_valid[g]),
        .match   (ent_match[g]),
        .age     (ent_age[g]),
        .key_z   (ent_z[g]),
        .key_x   (ent_x[g]),
        .key_y   (ent_y[g])
      );
    end
  endgenerate

  assign is_lookup = req_v && (req_cmd == CMD_LOOKUP);
  assign is_insert = req_v && (req_cmd == CMD_INSERT);
  assign is_probe  = req_v && (req_cmd == CMD_PROBE);
  assign is_remove = req_v && (req_cmd == CMD_REMOVE);
  assign is_clear  = req_v && (req_cmd == CMD_CLEAR);

  // effective limit
  always_comb begin
    lim_ext = LW'(limit);
    if (lim_ext == '0) begin
      lim_eff = LW'(1);
    end else if (lim_ext > LW'(ENTRIES)) begin
      lim_eff = LW'(ENTRIES);
    end else begin
      lim_eff = lim_ext;
    end
  end

  assign full       = LW'(occ) >= lim_eff;
  assign oldest_age = AW'(occ - 1'b1);
  assign any_hit    = |ent_match;
  assign ins_miss   = is_insert && !any_hit;
  assign evict      = ins_miss && full;

  // match and victim selection, keys are unique so matches are one-hot
  always_comb begin
    hit_idx = '0;
    hit_age = '0;
    vic_z   = '0;
    vic_x   = '0;
    vic_y   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = ent_valid[i] && (ent_age[i] == oldest_age);
      if (ent_match[i]) begin
        hit_idx = hit_idx | AW'(i);
        hit_age = hit_age | ent_age[i];
      end
      if (victim_oh[i]) begin
        vic_z = vic_z | ent_z[i];
        vic_x = vic_x | ent_x[i];
        vic_y = vic_y | ent_y[i];
      end
    end
  end

  // lowest free slot, counting the victim as freed
  assign free_vec = ~ent_valid | (evict ? victim_oh : '0);
  assign free_oh  = free_vec & (~free_vec + 1'b1);

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | AW'(i);
      end
    end
  end

  always_comb begin
    ctl.clear     = is_clear;
    ctl.inc_below = (is_lookup || is_insert) && any_hit;
    ctl.inc_all   = ins_miss;
    ctl.dec_above = is_remove && any_hit;
    ref_age       = hit_age;
    ent_touch     = (is_lookup || is_insert) ? ent_match : '0;
    ent_wr        = ins_miss ? free_oh : '0;
    if (is_remove) begin
      ent_kill = ent_match;
    end else if (evict) begin
      ent_kill = victim_oh;
    end else begin
      ent_kill = '0;
    end
  end

  always_comb begin
    occ_next = occ;
    if (is_clear) begin
      occ_next = '0;
    end else if (ins_miss && !evict) begin
      occ_next = occ + 1'b1;
    end else if (is_remove && any_hit) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  always_comb begin
    if (is_insert) begin
      slot_idx = any_hit ? hit_idx : free_idx;
    end else if (is_lookup && any_hit) begin
      slot_idx = hit_idx;
    end else begin
      slot_idx = '0;
    end
  end

  assign slot_wide = (AW + SlotW)'(slot_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_v;
    end
  end

  always_ff @(posedge clk) begin
    hit       <= (is_lookup || is_insert || is_probe || is_remove) && any_hit;
    slot      <= slot_wide[SlotW-1:0];
    evicted   <= evict;
    evicted_z <= evict ? vic_z : '0;
    evicted_x <= evict ? CoordW'(vic_x) : '0;
    evicted_y <= evict ? CoordW'(vic_y) : '0;
  end

endmodule

`default_nettype wire

FILE: verif/tb_lru_tile_cache_directory.sv
// ----------------------------------------------------------------------------
// tb_lru_tile_cache_directory
// Self-checking bench for the LRU tile cache directory: commands with keys
// from a small pool go in at random spacing across several capacity limits,
// and every result is checked against a behavioral copy of the directory.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_tile_cache_directory import lrud_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 64;
  localparam int POOL_KEYS   = 128;
  localparam int SETTLE      = 4;
  localparam int STALL_LIMIT = 500;
  localparam int NUM_PHASES  = 9;

  localparam logic [CmdW-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              evicted;
    logic [ZoomW-1:0]  ev_z;
    logic [CoordW-1:0] ev_x;
    logic [CoordW-1:0] ev_y;
  } dir_res_t;

  typedef struct {
    bit                is_cfg;
    logic [LimW-1:0]   lim;
    logic [CmdW-1:0]   cmd;
    logic [ZoomW-1:0]  z;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    int                gap;
  } dir_op_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              max_entries_we = 1'b0;
  logic [LimW-1:0]   max_entries = LIMIT_RESET;
  logic              start = 1'b0;
  logic              busy;
  logic [CmdW-1:0]   command = CMD_LOOKUP;
  logic [ZoomW-1:0]  tile_z = '0;
  logic [CoordW-1:0] tile_x = '0;
  logic [CoordW-1:0] tile_y = '0;
  logic              done;
  logic              hit;
  logic [SlotW-1:0]  slot;
  logic              evicted;
  logic [ZoomW-1:0]  evicted_z;
  logic [CoordW-1:0] evicted_x;
  logic [CoordW-1:0] evicted_y;

  lru_tile_cache_directory uut (
    .clk            (clk),
    .rst            (rst),
    .max_entries_we (max_entries_we),
    .max_entries    (max_entries),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .tile_z         (tile_z),
    .tile_x         (tile_x),
    .tile_y         (tile_y),
    .done           (done),
    .hit            (hit),
    .slot           (slot),
    .evicted        (evicted),
    .evicted_z      (evicted_z),
    .evicted_x      (evicted_x),
    .evicted_y      (evicted_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // directory copy
  logic              dir_valid [ENTRIES];
  logic [ZoomW-1:0]  dir_z [ENTRIES];
  logic [CoordW-1:0] dir_x [ENTRIES];
  logic [CoordW-1:0] dir_y [ENTRIES];
  int                dir_age [ENTRIES];
  int                dir_occ;
  int                dir_cap;

  dir_op_t  cmd_queue [$];
  dir_res_t pending_results [$];
  int       mismatch_cnt = 0;
  bit       took = 1'b0;
  int       quiet = 0;
  int       wait_cnt = 0;
  int       stall_cycles = 0;
  int       zero_run = 0;

  logic [ZoomW-1:0]  pool_z [POOL_KEYS];
  logic [CoordW-1:0] pool_x [POOL_KEYS];
  logic [CoordW-1:0] pool_y [POOL_KEYS];

  int  ph_lim   [NUM_PHASES] = '{64, 5, 127, 1, 0, 3, 65, 16, 64};
  int  ph_len   [NUM_PHASES] = '{130, 30, 40, 25, 20, 40, 30, 60, 30};
  int  ph_ins   [NUM_PHASES] = '{80, 50, 50, 50, 50, 45, 50, 45, 50};
  bit  ph_clear [NUM_PHASES] = '{1, 0, 1, 1, 1, 1, 1, 1, 0};

  // make slot s the most recent entry
  function automatic void touch_entry(int s);
    int a;
    a = dir_age[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_valid[i] && dir_age[i] < a) dir_age[i]++;
    end
    dir_age[s] = 0;
  endfunction

  function automatic void drop_entry(int s);
    int a;
    a = dir_age[s];
    dir_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_valid[i] && dir_age[i] > a) dir_age[i]--;
    end
    if (dir_occ > 0) dir_occ--;
  endfunction

  function automatic dir_res_t lru_access(logic [CmdW-1:0] c, logic [ZoomW-1:0] z,
                                          logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    dir_res_t r;
    int s;
    int v;
    int lim;
    r = '0;
    s = -1;
    v = -1;
    if (c == CMD_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 1'b0;
      dir_occ = 0;
    end else if (c <= CMD_REMOVE) begin
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (dir_valid[i] && dir_z[i] == z && dir_x[i] == x && dir_y[i] == y) s = i;
      end
      r.hit = (s >= 0);
      case (c)
        CMD_LOOKUP: begin
          if (s >= 0) begin
            touch_entry(s);
            r.slot = SlotW'(s);
          end
        end
        CMD_INSERT: begin
          if (s >= 0) begin
            touch_entry(s);
          end else begin
            lim = dir_cap;
            if (lim < 1) lim = 1;
            if (lim > ENTRIES) lim = ENTRIES;
            if (dir_occ >= lim) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (dir_valid[i] && (v < 0 || dir_age[i] > dir_age[v])) v = i;
              end
              if (v >= 0) begin
                r.evicted = 1'b1;
                r.ev_z = dir_z[v];
                r.ev_x = dir_x[v];
                r.ev_y = dir_y[v];
                drop_entry(v);
              end
            end
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (!dir_valid[i]) s = i;
            end
            for (int i = 0; i < ENTRIES; i++) begin
              if (dir_valid[i]) dir_age[i]++;
            end
            dir_valid[s] = 1'b1;
            dir_z[s] = z;
            dir_x[s] = x;
            dir_y[s] = y;
            dir_age[s] = 0;
            dir_occ++;
          end
          r.slot = SlotW'(s);
        end
        CMD_REMOVE: begin
          if (s >= 0) drop_entry(s);
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // key index below zero means a fresh random key
  task automatic add_op(logic [CmdW-1:0] c, int k);
    dir_op_t op;
    op.is_cfg = 1'b0;
    op.lim = '0;
    op.cmd = c;
    if (k < 0) begin
      op.z = ZoomW'($urandom);
      op.x = CoordW'($urandom);
      op.y = CoordW'($urandom);
    end else begin
      op.z = pool_z[k];
      op.x = pool_x[k];
      op.y = pool_y[k];
    end
    if (zero_run > 0) begin
      op.gap = 0;
      zero_run--;
    end else begin
      op.gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) zero_run = $urandom_range(4, 20);
    end
    cmd_queue.push_back(op);
  endtask

  task automatic add_cfg(int v);
    dir_op_t op;
    op.is_cfg = 1'b1;
    op.lim = LimW'(v);
    op.cmd = CMD_LOOKUP;
    op.z = '0;
    op.x = '0;
    op.y = '0;
    op.gap = 0;
    cmd_queue.push_back(op);
  endtask

  // driver
  always @(negedge clk) begin : drive
    logic n_start;
    logic n_we;
    dir_op_t op;
    n_start = start;
    n_we = 1'b0;
    if (rst) begin
      n_start = 1'b0;
    end else begin
      if (start && took) n_start = 1'b0;
      quiet = (pending_results.size() == 0 && !start) ? quiet + 1 : 0;
      if (!n_start && cmd_queue.size() > 0) begin
        if (cmd_queue[0].is_cfg) begin
          if (quiet > SETTLE) begin
            op = cmd_queue.pop_front();
            max_entries <= op.lim;
            n_we = 1'b1;
            quiet = 0;
          end
        end else if (wait_cnt < cmd_queue[0].gap) begin
          wait_cnt++;
        end else begin
          op = cmd_queue.pop_front();
          command <= op.cmd;
          tile_z <= op.z;
          tile_x <= op.x;
          tile_y <= op.y;
          wait_cnt = 0;
          n_start = 1'b1;
        end
      end
    end
    start <= n_start;
    max_entries_we <= n_we;
  end

  // monitor and checker
  always @(posedge clk) begin : observe
    dir_res_t want;
    dir_res_t got;
    took <= !rst && start && !busy;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        dir_valid[i] = 1'b0;
        dir_age[i] = 0;
      end
      dir_occ = 0;
      dir_cap = LIMIT_RESET;
    end else begin
      if (max_entries_we) dir_cap = max_entries;
      if (done) begin
        got = {hit, slot, evicted, evicted_z, evicted_x, evicted_y};
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result with no transfer pending: %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: hit %b/%b slot %0d/%0d evicted %b/%b key %0d,%h,%h / %0d,%h,%h",
                       want.hit, got.hit, want.slot, got.slot, want.evicted, got.evicted,
                       want.ev_z, want.ev_x, want.ev_y, got.ev_z, got.ev_x, got.ev_y);
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(lru_access(command, tile_z, tile_x, tile_y));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || max_entries_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int eff;
    int psize;
    int r;
    logic [CmdW-1:0] c;

    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_z[i] = ZoomW'($urandom);
      pool_x[i] = CoordW'($urandom);
      pool_y[i] = CoordW'($urandom);
    end
    pool_z[0] = '1;
    pool_x[0] = '1;
    pool_y[0] = '1;
    pool_z[1] = '0;
    pool_x[1] = '0;
    pool_y[1] = '0;

    // directed: two-entry directory
    add_cfg(2);
    add_op(CMD_INSERT, 2);
    add_op(CMD_INSERT, 3);
    add_op(CMD_LOOKUP, 2);
    add_op(CMD_INSERT, 4);
    add_op(CMD_PROBE, 2);
    add_op(CMD_PROBE, 5);
    add_op(CMD_LOOKUP, 5);
    add_op(CMD_INSERT, 2);
    add_op(CMD_REMOVE, 4);
    add_op(CMD_REMOVE, 4);
    add_op(CMD_LOOKUP, 4);
    add_op(CMD_INSERT, 0);
    add_op(CMD_INSERT, 1);
    add_op(CMD_LOOKUP, 0);
    for (int k = CMD_RSVD_FIRST; k <= CMD_RSVD_LAST; k++) add_op(CmdW'(k), 0);
    add_op(CMD_CLEAR, 0);
    add_op(CMD_LOOKUP, 0);
    // zero limit acts as one
    add_cfg(0);
    add_op(CMD_INSERT, 2);
    add_op(CMD_INSERT, 3);
    add_op(CMD_LOOKUP, 3);
    add_op(CMD_LOOKUP, 2);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (ph_clear[p]) add_op(CMD_CLEAR, 0);
      add_cfg(ph_lim[p]);
      eff = (ph_lim[p] < 1) ? 1 : (ph_lim[p] > ENTRIES) ? ENTRIES : ph_lim[p];
      psize = (eff + 4 > POOL_KEYS) ? POOL_KEYS : eff + 4;
      for (int n = 0; n < ph_len[p]; n++) begin
        if ($urandom_range(0, 99) < ph_ins[p]) begin
          c = CMD_INSERT;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) c = CMD_LOOKUP;
          else if (r < 64) c = CMD_PROBE;
          else if (r < 92) c = CMD_REMOVE;
          else if (r < 96) c = CMD_CLEAR;
          else c = CmdW'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end
        add_op(c, ($urandom_range(0, 99) < 85) ? $urandom_range(0, psize - 1) : -1);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || start || pending_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
